/* hdl/llcprx_pkg.sv */
// ----------------------------------------------------------------------------
// llcprx_pkg
// Types and constants shared by the LLCP receive connection tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package llcprx_pkg;

    // pdu byte count saturates one below this size (and never above 4095)
    localparam int MAX_PDU_BYTES = 4096;
    localparam int CNT_MAX_I     = (MAX_PDU_BYTES - 1 < 4095) ? (MAX_PDU_BYTES - 1) : 4095;
    localparam logic [11:0] CNT_MAX  = 12'(CNT_MAX_I);
    localparam logic [11:0] MIU_BASE = 12'd128;

    // ptype codes
    localparam logic [3:0] PT_SYMM = 4'd0;
    localparam logic [3:0] PT_DISC = 4'd5;
    localparam logic [3:0] PT_CC   = 4'd6;
    localparam logic [3:0] PT_DM   = 4'd7;
    localparam logic [3:0] PT_I    = 4'd12;
    localparam logic [3:0] PT_RR   = 4'd13;
    localparam logic [3:0] PT_RNR  = 4'd14;

    // tlv type codes
    localparam logic [7:0] TLV_MIUX = 8'd2;
    localparam logic [7:0] TLV_RW   = 8'd5;

    typedef enum logic [3:0] {
        EV_NONE      = 4'd0,
        EV_SYMM      = 4'd1,
        EV_CONNECTED = 4'd2,
        EV_DM        = 4'd3,
        EV_DISC      = 4'd4,
        EV_DATA      = 4'd5,
        EV_ACK       = 4'd6,
        EV_OTHER     = 4'd7,
        EV_SHORT     = 4'd8,
        EV_NO_SEQ    = 4'd9
    } event_kind_t;

    typedef enum logic [1:0] {
        LINK_CLOSED        = 2'd0,
        LINK_CONNECTING    = 2'd1,
        LINK_CONNECTED     = 2'd2,
        LINK_DISCONNECTING = 2'd3
    } link_state_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic        data_valid;
        logic [7:0]  data_byte;
        event_kind_t event_kind;
        logic [7:0]  close_reason;
        logic [11:0] info_length;
        link_state_t link_state;
        logic [5:0]  peer_sap;
        logic [11:0] peer_miu;
        logic [3:0]  peer_window;
        logic [3:0]  recv_seq;
        logic [3:0]  ack_seq;
    } out_item_t;

    // connect parameters collected from the cc tlvs
    typedef struct packed {
        logic        miux_ok;
        logic [10:0] miux_val;
        logic        rw_ok;
        logic [3:0]  rw_val;
    } cc_params_t;

endpackage

`default_nettype wire

/* hdl/llcp_rx_connection_tracker_unit.sv */
// ----------------------------------------------------------------------------
// llcp_rx_connection_tracker_unit
// Decodes received LLCP PDUs byte by byte and tracks the connection state.
// ----------------------------------------------------------------------------
//  channel  ports                     content
//  in       s_valid/s_ready/s_item    one pdu byte with last-byte mark
//  out      m_valid/m_ready/m_item    payload byte, event, connection state
//  config   cfg_we/cfg_wdata          remote sap, applied at once
//
//  One item per cycle: each byte is decoded in one pass into the output
//  register, so a new byte is taken every cycle while the output drains.
//  The output register stalls the input only when it is full and not taken.
//  Reset: link closed, miu 128, window 1, sequence numbers zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module llcp_rx_connection_tracker_unit
    import llcprx_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_item_t   s_item,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_item_t       m_item,
    input  wire logic       cfg_we,
    input  wire logic [5:0] cfg_wdata
);

    logic        accept;
    logic        m_valid_reg;
    out_item_t   m_item_reg, m_item_next;

    link_state_t link_reg, link_next;
    logic [5:0]  sap_reg, sap_next;
    logic [11:0] miu_reg, miu_next;
    logic [3:0]  win_reg, win_next;
    logic [3:0]  vr_reg, vr_next;
    logic [3:0]  va_reg, va_next;
    logic [11:0] cnt_reg, cnt_next;
    logic [7:0]  hdr0_reg, hdr0_next;
    logic [7:0]  hdr1_reg, hdr1_next;
    logic [7:0]  hdr2_reg, hdr2_next;
    logic [7:0]  first_reg, first_next;

    logic [3:0]  pt_cur, pt_fin;
    logic        seq_cur, seq_fin;
    logic        seq_byte, info_byte;
    logic [11:0] hdr_len_cur, hdr_len_fin, ilen;
    logic        pdu_end;
    cc_params_t  cc_params;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;
    assign pdu_end = accept && s_item.last_byte;

    // header decode from stored bytes
    assign pt_cur      = {hdr0_reg[1:0], hdr1_reg[7:6]};
    assign seq_cur     = (pt_cur == PT_I) || (pt_cur == PT_RR) || (pt_cur == PT_RNR);
    assign hdr_len_cur = seq_cur ? 12'd3 : 12'd2;
    assign seq_byte    = (cnt_reg == 12'd2) && seq_cur;
    assign info_byte   = (cnt_reg >= 12'd2) && !seq_byte;

    // cc tlv walker
    llcprx_tlv_scan u_tlv (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .feed        (accept && info_byte && (pt_cur == PT_CC)),
        .feed_byte   (s_item.rx_byte),
        .clear       (pdu_end),
        .params_next (cc_params)
    );

    // per-byte decode
    always_comb begin
        hdr0_next  = (cnt_reg == 12'd0) ? s_item.rx_byte : hdr0_reg;
        hdr1_next  = (cnt_reg == 12'd1) ? s_item.rx_byte : hdr1_reg;
        hdr2_next  = seq_byte ? s_item.rx_byte : hdr2_reg;
        first_next = (info_byte && cnt_reg == hdr_len_cur) ? s_item.rx_byte : first_reg;
        cnt_next   = (cnt_reg < CNT_MAX) ? cnt_reg + 12'd1 : cnt_reg;
    end

    // end of pdu: event and connection update
    assign pt_fin      = {hdr0_next[1:0], hdr1_next[7:6]};
    assign seq_fin     = (pt_fin == PT_I) || (pt_fin == PT_RR) || (pt_fin == PT_RNR);
    assign hdr_len_fin = seq_fin ? 12'd3 : 12'd2;
    assign ilen        = cnt_next - hdr_len_fin;

    always_comb begin
        link_next = link_reg;
        sap_next  = sap_reg;
        miu_next  = miu_reg;
        win_next  = win_reg;
        vr_next   = vr_reg;
        va_next   = va_reg;

        m_item_next             = '0;
        m_item_next.event_kind  = EV_NONE;
        m_item_next.data_valid  = info_byte && (pt_cur == PT_I);
        m_item_next.data_byte   = m_item_next.data_valid ? s_item.rx_byte : 8'd0;

        if (s_item.last_byte) begin
            if (cnt_next < 12'd2) begin
                m_item_next.event_kind = EV_SHORT;
            end else if (cnt_next < hdr_len_fin) begin
                m_item_next.event_kind = EV_NO_SEQ;
            end else begin
                m_item_next.info_length = ilen;
                unique case (pt_fin)
                    PT_SYMM: begin
                        m_item_next.event_kind = EV_SYMM;
                    end
                    PT_CC: begin
                        sap_next  = hdr1_next[5:0];
                        miu_next  = MIU_BASE +
                                    (cc_params.miux_ok ? {1'b0, cc_params.miux_val} : 12'd0);
                        win_next  = cc_params.rw_ok ? cc_params.rw_val : 4'd1;
                        link_next = LINK_CONNECTED;
                        m_item_next.event_kind = EV_CONNECTED;
                    end
                    PT_DM: begin
                        link_next = LINK_CLOSED;
                        m_item_next.event_kind   = EV_DM;
                        m_item_next.close_reason = (ilen != 12'd0) ? first_next : 8'd0;
                    end
                    PT_DISC: begin
                        link_next = LINK_CLOSED;
                        m_item_next.event_kind = EV_DISC;
                    end
                    PT_I: begin
                        vr_next = vr_reg + 4'd1;
                        va_next = hdr2_next[3:0];
                        m_item_next.event_kind = EV_DATA;
                    end
                    PT_RR, PT_RNR: begin
                        va_next = hdr2_next[3:0];
                        m_item_next.event_kind = EV_ACK;
                    end
                    default: begin
                        m_item_next.event_kind = EV_OTHER;
                    end
                endcase
            end
        end

        // remote sap register write
        if (cfg_we) begin
            sap_next = cfg_wdata;
        end

        m_item_next.link_state  = link_next;
        m_item_next.peer_sap    = sap_next;
        m_item_next.peer_miu    = miu_next;
        m_item_next.peer_window = win_next;
        m_item_next.recv_seq    = vr_next;
        m_item_next.ack_seq     = va_next;
    end

    // connection and pdu state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg  <= LINK_CLOSED;
            sap_reg   <= 6'd0;
            miu_reg   <= MIU_BASE;
            win_reg   <= 4'd1;
            vr_reg    <= 4'd0;
            va_reg    <= 4'd0;
            cnt_reg   <= 12'd0;
            hdr0_reg  <= 8'd0;
            hdr1_reg  <= 8'd0;
            hdr2_reg  <= 8'd0;
            first_reg <= 8'd0;
        end else begin
            if (accept || cfg_we) begin
                sap_reg <= sap_next;
            end
            if (accept) begin
                link_reg <= link_next;
                miu_reg  <= miu_next;
                win_reg  <= win_next;
                vr_reg   <= vr_next;
                va_reg   <= va_next;
                if (s_item.last_byte) begin
                    cnt_reg   <= 12'd0;
                    hdr0_reg  <= 8'd0;
                    hdr1_reg  <= 8'd0;
                    hdr2_reg  <= 8'd0;
                    first_reg <= 8'd0;
                end else begin
                    cnt_reg   <= cnt_next;
                    hdr0_reg  <= hdr0_next;
                    hdr1_reg  <= hdr1_next;
                    hdr2_reg  <= hdr2_next;
                    first_reg <= first_next;
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_item_reg <= m_item_next;
        end
    end

    // checks
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_MAX)
        else $error("byte count beyond saturation limit");

    a_cnt_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        pdu_end |=> cnt_reg == 12'd0)
        else $error("byte count not cleared after last byte");

    a_no_event_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_item_reg.event_kind == EV_NONE |->
            m_item_reg.info_length == 12'd0 && m_item_reg.close_reason == 8'd0)
        else $error("length or reason reported without event");

    a_data_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_item_reg.data_valid && m_item_reg.event_kind != EV_NONE |->
            m_item_reg.event_kind == EV_DATA)
        else $error("payload byte ends pdu with non-data event");

endmodule

`default_nettype wire

/* hdl/llcprx_tlv_scan.sv */
// ----------------------------------------------------------------------------
// llcprx_tlv_scan
// Walks the TLV list of a CC PDU and keeps the first MIUX and RW found.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module llcprx_tlv_scan
    import llcprx_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       feed,      // cc info byte accepted
    input  wire logic [7:0] feed_byte,
    input  wire logic       clear,     // pdu ends this cycle
    output cc_params_t      params_next
);

    typedef enum logic [2:0] {
        TLV_TYPE = 3'b001,
        TLV_LEN  = 3'b010,
        TLV_VAL  = 3'b100
    } tlv_phase_t;

    tlv_phase_t  phase_reg, phase_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  v0_reg, v0_next;
    logic [7:0]  v1_reg, v1_next;
    logic        miux_seen_reg, miux_seen_next;
    logic        rw_seen_reg, rw_seen_next;
    cc_params_t  params_reg;
    logic        done;
    logic [7:0]  k;

    // scan one byte
    always_comb begin
        phase_next     = phase_reg;
        type_next      = type_reg;
        len_next       = len_reg;
        rem_next       = rem_reg;
        v0_next        = v0_reg;
        v1_next        = v1_reg;
        miux_seen_next = miux_seen_reg;
        rw_seen_next   = rw_seen_reg;
        params_next    = params_reg;
        done           = 1'b0;
        k              = len_reg - rem_reg;
        if (feed) begin
            unique case (phase_reg)
                TLV_TYPE: begin
                    type_next  = feed_byte;
                    phase_next = TLV_LEN;
                end
                TLV_LEN: begin
                    len_next = feed_byte;
                    rem_next = feed_byte;
                    if (feed_byte == 8'd0) begin
                        done = 1'b1;
                    end else begin
                        phase_next = TLV_VAL;
                    end
                end
                TLV_VAL: begin
                    if (k == 8'd0) begin
                        v0_next = feed_byte;
                    end else if (k == 8'd1) begin
                        v1_next = feed_byte;
                    end
                    rem_next = rem_reg - 8'd1;
                    done     = (rem_next == 8'd0);
                end
                default: begin
                    phase_next = TLV_TYPE;
                end
            endcase
        end
        // tlv complete: keep only the first of each kind
        if (done) begin
            phase_next = TLV_TYPE;
            if (type_next == TLV_MIUX && !miux_seen_reg) begin
                miux_seen_next = 1'b1;
                if (len_next == 8'd2) begin
                    params_next.miux_ok  = 1'b1;
                    params_next.miux_val = {v0_next[2:0], v1_next};
                end
            end
            if (type_next == TLV_RW && !rw_seen_reg) begin
                rw_seen_next = 1'b1;
                if (len_next == 8'd1) begin
                    params_next.rw_ok  = 1'b1;
                    params_next.rw_val = v0_next[3:0];
                end
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            phase_reg        <= TLV_TYPE;
            miux_seen_reg    <= 1'b0;
            rw_seen_reg      <= 1'b0;
            params_reg.miux_ok <= 1'b0;
            params_reg.rw_ok   <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            miux_seen_reg    <= miux_seen_next;
            rw_seen_reg      <= rw_seen_next;
            params_reg.miux_ok <= params_next.miux_ok;
            params_reg.rw_ok   <= params_next.rw_ok;
        end
    end

    // tlv payload
    always_ff @(posedge aclk) begin
        type_reg            <= type_next;
        len_reg             <= len_next;
        rem_reg             <= rem_next;
        v0_reg              <= v0_next;
        v1_reg              <= v1_next;
        params_reg.miux_val <= params_next.miux_val;
        params_reg.rw_val   <= params_next.rw_val;
    end

endmodule

`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LLCP receive connection tracker. PDUs are sent
// one byte per item and every output item is compared field by field with a
// bit-accurate tracker model: directed header and parameter cases, a long
// PDU, an output stall and random traffic with and without idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
    import llcprx_pkg::*;

    localparam int STALL_CYCLES  = 200;
    localparam int PHASE_BYTES   = 445;
    localparam int LONG_PAYLOAD  = 200;
    localparam int MAX_PRINTED   = 40;

    typedef enum logic [1:0] {
        TLV_AT_KIND,
        TLV_AT_LEN,
        TLV_AT_VALUE
    } tlv_phase_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_item    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_item_t   m_item;
    logic        cfg_we    = 1'b0;
    logic [5:0]  cfg_wdata = '0;

    llcp_rx_connection_tracker_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // connection and pdu state of the tracker model
    link_state_t trk_link    = LINK_CLOSED;
    logic [5:0]  trk_sap     = '0;
    logic [11:0] trk_miu     = MIU_BASE;
    logic [3:0]  trk_window  = 4'd1;
    logic [3:0]  trk_vr      = '0;
    logic [3:0]  trk_va      = '0;
    logic [11:0] trk_count   = '0;
    logic [7:0]  trk_hdr0    = '0;
    logic [7:0]  trk_hdr1    = '0;
    logic [7:0]  trk_hdr2    = '0;
    logic [7:0]  trk_first   = '0;
    tlv_phase_t  tlv_phase   = TLV_AT_KIND;
    logic [7:0]  tlv_kind    = '0;
    logic [7:0]  tlv_len     = '0;
    logic [7:0]  tlv_rem     = '0;
    logic [7:0]  tlv_v0      = '0;
    logic [7:0]  tlv_v1      = '0;
    logic        miux_seen   = 1'b0;
    logic        rw_seen     = 1'b0;
    cc_params_t  cc_found    = '0;

    out_item_t   predicted_reports[$];
    logic [7:0]  pdu_buf[$];

    int mismatches     = 0;
    int bytes_sent     = 0;
    int pdus_sent      = 0;
    int src_idle_pct   = 0;
    int dst_idle_pct   = 0;
    int stall_requests = 0;
    int stall_served   = 0;
    int stall_left     = 0;
    int events_seen[16];

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // tracker model
    // ------------------------------------------------------------------------
    function automatic logic carries_seq(input logic [3:0] pt);
        return pt == PT_I || pt == PT_RR || pt == PT_RNR;
    endfunction

    function automatic logic known_ptype(input logic [3:0] pt);
        return carries_seq(pt) || pt == PT_SYMM || pt == PT_DISC || pt == PT_CC
            || pt == PT_DM;
    endfunction

    function automatic void clear_pdu_state();
        trk_count = '0;
        trk_hdr0  = '0;
        trk_hdr1  = '0;
        trk_hdr2  = '0;
        trk_first = '0;
        tlv_phase = TLV_AT_KIND;
        tlv_kind  = '0;
        tlv_len   = '0;
        tlv_rem   = '0;
        tlv_v0    = '0;
        tlv_v1    = '0;
        miux_seen = 1'b0;
        rw_seen   = 1'b0;
        cc_found  = '0;
    endfunction

    // only the first complete tlv of each kind counts, and only at its length
    function automatic void tlv_close();
        if (tlv_kind == TLV_MIUX && !miux_seen) begin
            miux_seen = 1'b1;
            if (tlv_len == 8'd2) begin
                cc_found.miux_ok  = 1'b1;
                cc_found.miux_val = {tlv_v0[2:0], tlv_v1};
            end
        end
        if (tlv_kind == TLV_RW && !rw_seen) begin
            rw_seen = 1'b1;
            if (tlv_len == 8'd1) begin
                cc_found.rw_ok  = 1'b1;
                cc_found.rw_val = tlv_v0[3:0];
            end
        end
        tlv_phase = TLV_AT_KIND;
    endfunction

    function automatic void tlv_take(input logic [7:0] b);
        logic [7:0] k;
        case (tlv_phase)
            TLV_AT_KIND: begin
                tlv_kind  = b;
                tlv_phase = TLV_AT_LEN;
            end
            TLV_AT_LEN: begin
                tlv_len = b;
                tlv_rem = b;
                if (b == 8'd0) tlv_close();
                else tlv_phase = TLV_AT_VALUE;
            end
            default: begin
                k = tlv_len - tlv_rem;
                if (k == 8'd0) tlv_v0 = b;
                else if (k == 8'd1) tlv_v1 = b;
                tlv_rem = tlv_rem - 8'd1;
                if (tlv_rem == 8'd0) tlv_close();
            end
        endcase
    endfunction

    // one pdu byte in, one output item out
    function automatic out_item_t track_rx_byte(input in_item_t it);
        out_item_t  r;
        logic [3:0] pt;
        int         hdr_len;
        int         pos;
        int         n;
        r       = '0;
        pos     = int'(trk_count);
        pt      = {trk_hdr0[1:0], trk_hdr1[7:6]};
        hdr_len = carries_seq(pt) ? 3 : 2;

        // header bytes, then info field
        if (pos == 0) begin
            trk_hdr0 = it.rx_byte;
        end else if (pos == 1) begin
            trk_hdr1 = it.rx_byte;
        end else if (pos == 2 && hdr_len == 3) begin
            trk_hdr2 = it.rx_byte;
        end else begin
            if (pos == hdr_len) trk_first = it.rx_byte;
            if (pt == PT_I) begin
                r.data_valid = 1'b1;
                r.data_byte  = it.rx_byte;
            end
            if (pt == PT_CC) tlv_take(it.rx_byte);
        end
        if (trk_count < CNT_MAX) trk_count = trk_count + 12'd1;

        // event and connection update on the last byte
        r.event_kind = EV_NONE;
        if (it.last_byte) begin
            n       = int'(trk_count);
            pt      = {trk_hdr0[1:0], trk_hdr1[7:6]};
            hdr_len = carries_seq(pt) ? 3 : 2;
            if (n < 2) begin
                r.event_kind = EV_SHORT;
            end else if (n < hdr_len) begin
                r.event_kind = EV_NO_SEQ;
            end else begin
                r.info_length = 12'(n - hdr_len);
                case (pt)
                    PT_SYMM: r.event_kind = EV_SYMM;
                    PT_CC: begin
                        trk_sap    = trk_hdr1[5:0];
                        trk_miu    = MIU_BASE + (cc_found.miux_ok ?
                                     {1'b0, cc_found.miux_val} : 12'd0);
                        trk_window = cc_found.rw_ok ? cc_found.rw_val : 4'd1;
                        trk_link   = LINK_CONNECTED;
                        r.event_kind = EV_CONNECTED;
                    end
                    PT_DM: begin
                        trk_link       = LINK_CLOSED;
                        r.event_kind   = EV_DM;
                        r.close_reason = (n != hdr_len) ? trk_first : 8'd0;
                    end
                    PT_DISC: begin
                        trk_link     = LINK_CLOSED;
                        r.event_kind = EV_DISC;
                    end
                    PT_I: begin
                        trk_vr       = trk_vr + 4'd1;
                        trk_va       = trk_hdr2[3:0];
                        r.event_kind = EV_DATA;
                    end
                    PT_RR, PT_RNR: begin
                        trk_va       = trk_hdr2[3:0];
                        r.event_kind = EV_ACK;
                    end
                    default: r.event_kind = EV_OTHER;
                endcase
            end
            clear_pdu_state();
        end

        r.link_state  = trk_link;
        r.peer_sap    = trk_sap;
        r.peer_miu    = trk_miu;
        r.peer_window = trk_window;
        r.recv_seq    = trk_vr;
        r.ack_seq     = trk_va;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // prediction on accepted items, checking of accepted results
    // ------------------------------------------------------------------------
    task automatic compare_field(input string field, input int want, input int got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn) begin
            if (s_valid && s_ready) predicted_reports.push_back(track_rx_byte(s_item));
            if (m_valid && m_ready) begin
                if (predicted_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_PRINTED)
                        $display("%0t: result with nothing expected, event %0d",
                                 $time, int'(m_item.event_kind));
                end else begin
                    want = predicted_reports.pop_front();
                    events_seen[want.event_kind]++;
                    compare_field("data_valid", want.data_valid, m_item.data_valid);
                    compare_field("data_byte", want.data_byte, m_item.data_byte);
                    compare_field("event_kind", int'(want.event_kind),
                                  int'(m_item.event_kind));
                    compare_field("close_reason", want.close_reason, m_item.close_reason);
                    compare_field("info_length", want.info_length, m_item.info_length);
                    compare_field("link_state", int'(want.link_state),
                                  int'(m_item.link_state));
                    compare_field("peer_sap", want.peer_sap, m_item.peer_sap);
                    compare_field("peer_miu", want.peer_miu, m_item.peer_miu);
                    compare_field("peer_window", want.peer_window, m_item.peer_window);
                    compare_field("recv_seq", want.recv_seq, m_item.recv_seq);
                    compare_field("ack_seq", want.ack_seq, m_item.ack_seq);
                end
            end
        end
    end

    // receiver: random idling, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_requests != stall_served) begin
            stall_served = stall_requests;
            stall_left   = STALL_CYCLES;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last);
        in_item_t item;
        int       gap;
        item.rx_byte   = b;
        item.last_byte = last;
        if ($urandom_range(99) < src_idle_pct) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_pdu();
        foreach (pdu_buf[i]) send_byte(pdu_buf[i], i == pdu_buf.size() - 1);
        pdus_sent++;
        pdu_buf.delete();
    endtask

    function automatic void start_pdu(input logic [3:0] pt, input logic [5:0] dsap,
                                      input logic [5:0] ssap);
        pdu_buf.delete();
        pdu_buf.push_back({dsap, pt[3:2]});
        pdu_buf.push_back({pt[1:0], ssap});
    endfunction

    function automatic void add_random_bytes(input int count);
        repeat (count) pdu_buf.push_back(8'($urandom));
    endfunction

    // connect parameter tlvs: mostly well formed, some bad lengths or cut off
    function automatic void add_cc_tlvs();
        int         sel;
        int         len;
        logic [7:0] kind;
        repeat ($urandom_range(0, 4)) begin
            sel = $urandom_range(9);
            if (sel < 4) kind = TLV_MIUX;
            else if (sel < 8) kind = TLV_RW;
            else kind = 8'($urandom);
            if ($urandom_range(9) < 7)
                len = (kind == TLV_MIUX) ? 2 : (kind == TLV_RW) ? 1 : $urandom_range(0, 3);
            else
                len = $urandom_range(0, 4);
            pdu_buf.push_back(kind);
            pdu_buf.push_back(8'(len));
            add_random_bytes(len);
        end
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 3)) if (pdu_buf.size() > 2) void'(pdu_buf.pop_back());
    endfunction

    function automatic void build_random_pdu();
        int         kind;
        logic [3:0] pt;
        logic [5:0] dsap;
        logic [5:0] ssap;
        kind = $urandom_range(99);
        dsap = 6'($urandom);
        ssap = 6'($urandom);
        if (kind < 10) begin
            // noise: any bytes at all
            pdu_buf.delete();
            add_random_bytes($urandom_range(1, 6));
        end else if (kind < 16) begin
            // cut short: a sequenced pdu without its seq byte, or only its first header byte
            pt = ($urandom_range(1) == 1) ? PT_I : ($urandom_range(1) ? PT_RR : PT_RNR);
            start_pdu(pt, dsap, ssap);
            if ($urandom_range(2) == 0) void'(pdu_buf.pop_back());
        end else begin
            case ($urandom_range(9))
                0: begin
                    start_pdu(PT_SYMM, dsap, ssap);
                    add_random_bytes($urandom_range(0, 2));
                end
                1, 2, 3: begin
                    start_pdu(PT_CC, dsap, ssap);
                    add_cc_tlvs();
                end
                4: begin
                    start_pdu(PT_DM, dsap, ssap);
                    add_random_bytes($urandom_range(0, 3));
                end
                5: begin
                    start_pdu(PT_DISC, dsap, ssap);
                    add_random_bytes($urandom_range(0, 1));
                end
                6, 7: begin
                    start_pdu(PT_I, dsap, ssap);
                    add_random_bytes(1);
                    add_random_bytes($urandom_range(5) == 0 ? $urandom_range(13, 40)
                                                            : $urandom_range(0, 12));
                end
                8: begin
                    start_pdu($urandom_range(1) ? PT_RR : PT_RNR, dsap, ssap);
                    add_random_bytes(1);
                    add_random_bytes($urandom_range(3) == 0 ? 1 : 0);
                end
                default: begin
                    do pt = 4'($urandom_range(15)); while (known_ptype(pt));
                    start_pdu(pt, dsap, ssap);
                    add_random_bytes($urandom_range(0, 3));
                end
            endcase
        end
    endfunction

    // let every expected result arrive
    task automatic drain_reports();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (predicted_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // remote sap write, only while the block is idle
    task automatic write_sap(input logic [5:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        trk_sap   = value;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed_pdus();
        src_idle_pct = 0;
        dst_idle_pct = 0;
        // single byte, too short
        pdu_buf.delete();
        pdu_buf.push_back(8'hFF);
        send_pdu();
        // symm with all-zero header
        start_pdu(PT_SYMM, 6'd0, 6'd0);
        send_pdu();
        // i pdu without its sequence byte, all-ones saps
        start_pdu(PT_I, 6'd63, 6'd63);
        send_pdu();
        // i pdu with payload at the byte extremes
        start_pdu(PT_I, 6'd0, 6'd1);
        pdu_buf.push_back(8'hA5);
        pdu_buf.push_back(8'hFF);
        pdu_buf.push_back(8'h00);
        send_pdu();
        // receiver ready acknowledges
        start_pdu(PT_RR, 6'd2, 6'd3);
        pdu_buf.push_back(8'h3C);
        send_pdu();
        // connect with largest miux and window
        start_pdu(PT_CC, 6'd1, 6'd42);
        pdu_buf.push_back(TLV_MIUX);
        pdu_buf.push_back(8'd2);
        pdu_buf.push_back(8'hFF);
        pdu_buf.push_back(8'hFF);
        pdu_buf.push_back(TLV_RW);
        pdu_buf.push_back(8'd1);
        pdu_buf.push_back(8'h0F);
        send_pdu();
        // dm with reason byte, dm without info, disc
        start_pdu(PT_DM, 6'd42, 6'd1);
        pdu_buf.push_back(8'h81);
        send_pdu();
        start_pdu(PT_DM, 6'd42, 6'd1);
        send_pdu();
        start_pdu(PT_DISC, 6'd42, 6'd1);
        send_pdu();
        drain_reports();
    endtask

    // long i pdu, well past the usual payload sizes
    task automatic test_long_pdu();
        src_idle_pct = 0;
        dst_idle_pct = 0;
        start_pdu(PT_I, 6'd5, 6'd9);
        add_random_bytes(1);
        add_random_bytes(LONG_PAYLOAD);
        send_pdu();
        drain_reports();
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_output_stall();
        int start_bytes;
        src_idle_pct = 0;
        dst_idle_pct = 0;
        start_bytes  = bytes_sent;
        stall_requests++;
        while (bytes_sent - start_bytes < 60) begin
            build_random_pdu();
            send_pdu();
        end
        drain_reports();
    endtask

    task automatic test_random_traffic(input int src_pct, input int dst_pct,
                                       input logic [5:0] sap);
        int start_bytes;
        write_sap(sap);
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        start_bytes  = bytes_sent;
        while (bytes_sent - start_bytes < PHASE_BYTES) begin
            build_random_pdu();
            send_pdu();
        end
        drain_reports();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        foreach (events_seen[i]) events_seen[i] = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_pdus();
        test_random_traffic(17, 85, 6'd63);
        test_random_traffic(85, 17, 6'd0);
        test_output_stall();
        test_long_pdu();
        test_random_traffic(0, 0, 6'($urandom));

        drain_reports();
        repeat (8) @(posedge aclk);
        $display("covered %0d pdus in %0d bytes: %0d connects, %0d data, %0d acks, %0d dm",
                 pdus_sent, bytes_sent, events_seen[EV_CONNECTED], events_seen[EV_DATA],
                 events_seen[EV_ACK], events_seen[EV_DM]);
        $display("plus %0d short, %0d missing seq, %0d other, one long pdu, one stall",
                 events_seen[EV_SHORT], events_seen[EV_NO_SEQ], events_seen[EV_OTHER]);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("%0t: timeout", $time);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
